// ----- hw/rtl/pscu_pkg.sv -----
package pscu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CoefW = 16;
  localparam int unsigned RawW  = 19;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned CfgW  = 48;

  localparam logic [IdxW-1:0] REG_AC123 = 3'd0;
  localparam logic [IdxW-1:0] REG_AC456 = 3'd1;
  localparam logic [IdxW-1:0] REG_B12   = 3'd2;
  localparam logic [IdxW-1:0] REG_MCMD  = 3'd3;
  localparam logic [IdxW-1:0] REG_OSS   = 3'd4;

  localparam logic [WordW-1:0] B6_OFS  = 32'd4000;
  localparam logic [WordW-1:0] B4_OFS  = 32'd32768;
  localparam logic [WordW-1:0] B7_BASE = 32'd50000;
  localparam logic [WordW-1:0] P1      = 32'd3038;
  localparam logic [WordW-1:0] P2_NEG  = 32'hFFFF_E343;
  localparam logic [WordW-1:0] P3      = 32'd3791;
  localparam logic [1:0]       OSS_RST = 2'd3;

  typedef struct packed {
    logic [CoefW-1:0] ac1;
    logic [CoefW-1:0] ac2;
    logic [CoefW-1:0] ac3;
    logic [CoefW-1:0] ac4;
    logic [CoefW-1:0] ac5;
    logic [CoefW-1:0] ac6;
    logic [CoefW-1:0] b1;
    logic [CoefW-1:0] b2;
    logic [CoefW-1:0] mc;
    logic [CoefW-1:0] md;
    logic [1:0]       oss;
  } cal_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             kind;
    logic             err;
  } res_t;

  function automatic logic [WordW-1:0] sext16(input logic [CoefW-1:0] v);
    return {{(WordW-CoefW){v[CoefW-1]}}, v};
  endfunction

  function automatic logic [WordW-1:0] asr32(input logic [WordW-1:0] v,
                                             input logic [4:0] n);
    return WordW'($signed(v) >>> n);
  endfunction

  // signed divide by four, truncating toward zero
  function automatic logic [WordW-1:0] sdiv4(input logic [WordW-1:0] v);
    logic [WordW-1:0] t;
    t = v + (v[WordW-1] ? 32'd3 : 32'd0);
    return asr32(t, 5'd2);
  endfunction

endpackage

// ----- hw/rtl/pscu_div.sv -----
module pscu_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pscu_pkg::WordW-1:0]   dividend,
  input  logic [pscu_pkg::WordW-1:0]   divisor,
  output logic                         done,
  output logic [pscu_pkg::WordW-1:0]   quotient
);

  logic                       busy_r;
  logic                       done_r;
  logic [4:0]                 cnt_r;
  logic [pscu_pkg::WordW-1:0] dvd_r;
  logic [pscu_pkg::WordW-1:0] dvs_r;
  logic [pscu_pkg::WordW-1:0] rem_r;
  logic [pscu_pkg::WordW:0]   trial;

  assign trial = {rem_r, dvd_r[pscu_pkg::WordW-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (trial[pscu_pkg::WordW]) begin
          rem_r <= {rem_r[pscu_pkg::WordW-2:0], dvd_r[pscu_pkg::WordW-1]};
          dvd_r <= {dvd_r[pscu_pkg::WordW-2:0], 1'b0};
        end else begin
          rem_r <= trial[pscu_pkg::WordW-1:0];
          dvd_r <= {dvd_r[pscu_pkg::WordW-2:0], 1'b1};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- hw/rtl/pscu_core.sv -----
module pscu_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        cmd,
  input  logic [pscu_pkg::RawW-1:0]   raw,
  input  pscu_pkg::cal_t              cal,
  input  logic                        res_take,
  output logic                        busy,
  output logic                        res_valid,
  output pscu_pkg::res_t              res
);

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T1, S_TW,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_PW,
    S_P9, S_P10, S_P11, S_P12, S_DONE
  } state_t;

  state_t                     state_r;
  logic                       cmd_r;
  logic [pscu_pkg::RawW-1:0]  raw_r;
  logic [pscu_pkg::WordW-1:0] prod_r, x_r, sq_r, t1_r, t2_r, b3_r, b4_r, pv_r;
  logic [pscu_pkg::WordW-1:0] val_r, tt_r;
  logic                       err_r, neg_r;

  logic [pscu_pkg::WordW-1:0] ma, mb;
  logic                       div_start;
  logic [pscu_pkg::WordW-1:0] div_a, div_b, div_q;
  logic                       div_done;
  logic [pscu_pkg::WordW-1:0] raw32, b6, x1, den, num, q_s, b5, x3, p;

  assign raw32 = {{(pscu_pkg::WordW-pscu_pkg::RawW){1'b0}}, raw_r};
  assign b6    = tt_r - pscu_pkg::B6_OFS;
  assign x1    = pscu_pkg::asr32(prod_r, 5'd15);
  assign den   = x1 + pscu_pkg::sext16(cal.md);
  assign num   = pscu_pkg::sext16(cal.mc) << 11;
  assign q_s   = neg_r ? (32'd0 - div_q) : div_q;
  assign b5    = x_r + q_s;
  assign x3    = t1_r + pscu_pkg::asr32(prod_r, 5'd11);
  assign p     = neg_r ? (div_q << 1) : div_q;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_T0: begin
        ma = raw32 - {16'd0, cal.ac6};
        mb = {16'd0, cal.ac5};
      end
      S_P0: begin
        ma = b6;
        mb = b6;
      end
      S_P1: begin
        ma = pscu_pkg::sext16(cal.b2);
        mb = pscu_pkg::asr32(prod_r, 5'd12);
      end
      S_P2: begin
        ma = pscu_pkg::sext16(cal.ac2);
        mb = x_r;
      end
      S_P3: begin
        ma = pscu_pkg::sext16(cal.ac3);
        mb = x_r;
      end
      S_P4: begin
        ma = pscu_pkg::sext16(cal.b1);
        mb = sq_r;
      end
      S_P6: begin
        ma = {16'd0, cal.ac4};
        mb = t2_r + pscu_pkg::B4_OFS;
      end
      S_P7: begin
        ma = raw32 - b3_r;
        mb = pscu_pkg::B7_BASE >> cal.oss;
      end
      S_P9: begin
        ma = pscu_pkg::asr32(pv_r, 5'd8);
        mb = pscu_pkg::asr32(pv_r, 5'd8);
      end
      S_P10: begin
        ma = prod_r;
        mb = pscu_pkg::P1;
      end
      S_P11: begin
        ma = pscu_pkg::P2_NEG;
        mb = pv_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state_r)
      S_T1: begin
        div_start = (den != '0);
        div_a     = num[pscu_pkg::WordW-1] ? (32'd0 - num) : num;
        div_b     = den[pscu_pkg::WordW-1] ? (32'd0 - den) : den;
      end
      S_P8: begin
        div_start = (b4_r != '0);
        div_a     = prod_r[pscu_pkg::WordW-1] ? prod_r : (prod_r << 1);
        div_b     = b4_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pscu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tt_r    <= '0;
    end else begin
      prod_r <= ma * mb;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= cmd;
            raw_r   <= raw;
            state_r <= cmd ? S_P0 : S_T0;
          end
        end
        S_T0: state_r <= S_T1;
        S_T1: begin
          x_r   <= x1;
          neg_r <= num[pscu_pkg::WordW-1] ^ den[pscu_pkg::WordW-1];
          if (den == '0) begin
            val_r   <= '0;
            err_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_TW;
          end
        end
        S_TW: begin
          if (div_done) begin
            tt_r    <= b5;
            val_r   <= pscu_pkg::asr32(b5 + 32'd8, 5'd4);
            err_r   <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_P0: begin
          x_r     <= b6;
          state_r <= S_P1;
        end
        S_P1: begin
          sq_r    <= pscu_pkg::asr32(prod_r, 5'd12);
          state_r <= S_P2;
        end
        S_P2: begin
          t1_r    <= pscu_pkg::asr32(prod_r, 5'd11);
          state_r <= S_P3;
        end
        S_P3: begin
          b3_r    <= pscu_pkg::sdiv4((((pscu_pkg::sext16(cal.ac1) << 2) + x3) << cal.oss)
                     + 32'd2);
          state_r <= S_P4;
        end
        S_P4: begin
          t2_r    <= pscu_pkg::asr32(prod_r, 5'd13);
          state_r <= S_P5;
        end
        S_P5: begin
          t2_r    <= pscu_pkg::sdiv4(t2_r + pscu_pkg::asr32(prod_r, 5'd16) + 32'd2);
          state_r <= S_P6;
        end
        S_P6: state_r <= S_P7;
        S_P7: begin
          b4_r    <= prod_r >> 15;
          state_r <= S_P8;
        end
        S_P8: begin
          neg_r <= prod_r[pscu_pkg::WordW-1];
          if (b4_r == '0) begin
            val_r   <= '0;
            err_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_PW;
          end
        end
        S_PW: begin
          if (div_done) begin
            pv_r    <= p;
            state_r <= S_P9;
          end
        end
        S_P9:  state_r <= S_P10;
        S_P10: state_r <= S_P11;
        S_P11: begin
          t1_r    <= pscu_pkg::asr32(prod_r, 5'd16);
          state_r <= S_P12;
        end
        S_P12: begin
          val_r   <= pv_r + pscu_pkg::asr32(t1_r + pscu_pkg::asr32(prod_r, 5'd16)
                     + pscu_pkg::P3, 5'd4);
          err_r   <= 1'b0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.value = val_r;
  assign res.kind  = cmd_r;
  assign res.err   = err_r;

endmodule

// ----- hw/rtl/pressure_sensor_compensation_unit.sv -----
// Integer barometric compensation. A temperature transaction (cmd 0) and a
// pressure transaction (cmd 1) each spend most of their time in the radix-2
// divider; the remaining steps share one 32x32 multiplier under a small
// sequencer. The input is stalled while a transaction is in work; a finished
// result sits in the output register so the next input can be taken while it
// waits. Pressure uses the B5 term of the last good temperature (0 after
// reset). A zero divisor gives value 0 with div_error.
module pressure_sensor_compensation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [pscu_pkg::RawW-1:0]         in_raw_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pscu_pkg::WordW-1:0] out_value,
  output logic                              out_kind,
  output logic                              out_div_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pscu_pkg::IdxW-1:0]         cfg_index,
  input  logic [pscu_pkg::CfgW-1:0]         cfg_wdata
);

  pscu_pkg::cal_t cal_r;
  pscu_pkg::res_t res, out_r;
  logic           out_valid_r;
  logic           busy, res_valid, take;

  assign cfg_ready = 1'b1;
  assign take      = !out_valid_r || !out_stall;
  assign in_stall  = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // oversampling sits in the low bits of the packed calibration word
      cal_r <= {{(10*pscu_pkg::CoefW){1'b0}}, pscu_pkg::OSS_RST};
    end else if (cfg_valid) begin
      case (cfg_index)
        pscu_pkg::REG_AC123: begin
          cal_r.ac1 <= cfg_wdata[15:0];
          cal_r.ac2 <= cfg_wdata[31:16];
          cal_r.ac3 <= cfg_wdata[47:32];
        end
        pscu_pkg::REG_AC456: begin
          cal_r.ac4 <= cfg_wdata[15:0];
          cal_r.ac5 <= cfg_wdata[31:16];
          cal_r.ac6 <= cfg_wdata[47:32];
        end
        pscu_pkg::REG_B12: begin
          cal_r.b1 <= cfg_wdata[15:0];
          cal_r.b2 <= cfg_wdata[31:16];
        end
        pscu_pkg::REG_MCMD: begin
          cal_r.mc <= cfg_wdata[15:0];
          cal_r.md <= cfg_wdata[31:16];
        end
        pscu_pkg::REG_OSS: cal_r.oss <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  pscu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && !busy),
    .cmd       (in_cmd),
    .raw       (in_raw_value),
    .cal       (cal_r),
    .res_take  (take),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_valid;
      if (res_valid) out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_r.value;
  assign out_kind      = out_r.kind;
  assign out_div_error = out_r.err;

endmodule

// ----- hw/rtl/pscu_checker.sv -----
module pscu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pscu_pkg::WordW-1:0]  out_value,
  input logic                        out_div_error
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value))
    else $error("stalled result changed");

  // the block goes busy after taking a transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after accept");

  // error results carry a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_error |-> out_value == '0)
    else $error("error result with nonzero value");

endmodule

bind pressure_sensor_compensation_unit pscu_checker u_pscu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value     (out_value),
  .out_div_error (out_div_error)
);
